FILE: rtl/cascaded_position_speed_pid_core_assert.svh
`ifndef CASCADED_POSITION_SPEED_PID_CORE_ASSERT_SVH
`define CASCADED_POSITION_SPEED_PID_CORE_ASSERT_SVH
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded position/speed PID core.
// Both expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------

// The consequent must hold in the same cycle as the antecedent.
`define CPSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cpsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpsp_pkg
// Shared widths, constants, register indexes and types of the cascaded
// position/speed PID core.
// ----------------------------------------------------------------------------
package cpsp_pkg;

    localparam int FRAC_BITS_DEF      = 12;
    localparam int INTEGRAL_WIDTH_DEF = 48;

    localparam int SPD_W       = 16;
    localparam int POS_W       = 32;
    localparam int GAIN_W      = 16;
    localparam int DUTY_W      = 7;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Error and error-difference registers hold either loop's values.
    localparam int EO_W = POS_W + 1;
    localparam int ED_W = POS_W + 2;

    // Shared multiplier: operands are split into two chunks.
    localparam int OP_W    = 64;
    localparam int CHUNK_W = 32;
    localparam int PROD_W  = GAIN_W + 1 + CHUNK_W + 1;
    localparam int ACC_W   = OP_W + GAIN_W + 3;

    // Three terms times two chunks, then a step that drains the product register.
    localparam int MAC_ISSUES = 6;
    localparam int STEP_W     = 3;
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(MAC_ISSUES);
    localparam logic [STEP_W-1:0] STEP_ISSUE = STEP_W'(MAC_ISSUES);

    localparam int OUTER_LIMIT = 110;
    localparam int INNER_LIMIT = 90;

    localparam logic [GAIN_W-1:0] OUTER_KP_RST = GAIN_W'(819);
    localparam logic [GAIN_W-1:0] OUTER_KI_RST = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] OUTER_KD_RST = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] INNER_KP_RST = GAIN_W'(1638);
    localparam logic [GAIN_W-1:0] INNER_KI_RST = GAIN_W'(205);
    localparam logic [GAIN_W-1:0] INNER_KD_RST = GAIN_W'(0);

    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI        = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD        = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KP        = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KI        = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KD        = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_TARGET = CFG_IDX_W'(6);

    localparam logic [1:0] TERM_P = 2'd0;
    localparam logic [1:0] TERM_I = 2'd1;
    localparam logic [1:0] TERM_D = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] outer_kp;
        logic [GAIN_W-1:0] outer_ki;
        logic [GAIN_W-1:0] outer_kd;
        logic [GAIN_W-1:0] inner_kp;
        logic [GAIN_W-1:0] inner_ki;
        logic [GAIN_W-1:0] inner_kd;
        logic [POS_W-1:0]  position_target;
    } cpsp_gains_t;

    typedef struct packed {
        logic issue;  // launch one multiply
        logic first;  // this product starts a new sum
        logic hi;     // multiply the upper chunk
    } cpsp_mac_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OERR,
        ST_OMAC,
        ST_OCLAMP,
        ST_IERR,
        ST_IMAC,
        ST_FINISH
    } cpsp_state_t;

endpackage
`default_nettype wire

FILE: rtl/cascaded_position_speed_pid_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_position_speed_pid_core
// Cascaded position/speed PID controller built around one shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the s_axis channel is one control tick carrying a signed
// encoder count. The count is added to a saturating position accumulator,
// the outer position PID produces a speed target clamped to +-110, and the
// inner speed PID produces a drive clamped to +-90 and truncated toward zero.
// Each tick yields one m_axis beat with duty, direction and position.
// Gains and the position target are written on the cfg channel, which is
// always ready; write them only while no tick is in flight.
// Steps: a tick runs the outer error step, then the outer loop's multiplies on
// the shared 16x33 multiplier (three terms of two chunks) and a step that drains
// its product register, then the outer clamp, the inner error step, the same
// multiplies and drain for the inner loop, and a finish step that loads the
// output. s_axis_tready is high only while the sequencer is idle, so the next
// tick is accepted only once the sequencer has finished the last one.
// The result sits in an output register; the next tick may be accepted while
// it waits. If the receiver still stalls when the next result is done, the
// sequencer holds in its last step until the output register is free.
// Reset clears the gains to their defaults, the target, the position and
// both loops' integrators and previous errors, and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
`include "cascaded_position_speed_pid_core_assert.svh"

module cascaded_position_speed_pid_core #(
    parameter int FRAC_BITS      = cpsp_pkg::FRAC_BITS_DEF,
    parameter int INTEGRAL_WIDTH = cpsp_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] speed_count
    input  logic [cpsp_pkg::SPD_W-1:0]          s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [6:0] duty, [7] reverse, [39:8] position
    output logic [cpsp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cpsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cpsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cpsp_pkg::*;

    localparam int UoW  = FRAC_BITS + 8;
    localparam int EiW  = FRAC_BITS + 17;
    localparam int DiW  = EiW + 1;
    localparam int UiW  = 2 * FRAC_BITS + 8;
    localparam int SumW = INTEGRAL_WIDTH + 3;

    localparam logic signed [ACC_W-1:0] OuterLim = ACC_W'(OUTER_LIMIT) <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0] InnerLim = ACC_W'(INNER_LIMIT) <<< (2 * FRAC_BITS);
    localparam logic signed [UoW-1:0]   UoLim    = UoW'(OUTER_LIMIT) <<< FRAC_BITS;
    localparam logic signed [SumW-1:0]  IntMax   = (SumW'(1) <<< (INTEGRAL_WIDTH - 1)) - SumW'(1);
    localparam logic signed [SumW-1:0]  IntMin   = -IntMax - SumW'(1);

    cpsp_gains_t   gains;
    cpsp_mac_ctl_t mac_ctl;

    cpsp_state_t   state_reg;
    cpsp_state_t   state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    logic signed [SPD_W-1:0]          spd_reg;
    logic signed [POS_W-1:0]          pos_reg;
    logic signed [POS_W-1:0]          pos_next;
    logic signed [POS_W:0]            pos_sum;
    logic signed [INTEGRAL_WIDTH-1:0] oint_reg;
    logic signed [INTEGRAL_WIDTH-1:0] iint_reg;
    logic signed [EO_W-1:0]           oprev_reg;
    logic signed [EiW-1:0]            iprev_reg;
    logic signed [EO_W-1:0]           e_reg;
    logic signed [ED_W-1:0]           d_reg;
    logic signed [UoW-1:0]            uo_reg;
    logic                             out_valid_reg;
    logic [OUT_TDATA_W-1:0]           out_data_reg;

    logic                             in_beat;
    logic                             inner_err;
    logic                             out_load;
    logic signed [EO_W-1:0]           eo;
    logic signed [EiW-1:0]            ei;
    logic signed [EO_W-1:0]           err_cur;
    logic signed [ED_W-1:0]           prev_cur;
    logic signed [ED_W-1:0]           diff;
    logic signed [INTEGRAL_WIDTH-1:0] integ_cur;
    logic signed [SumW-1:0]           integ_sum;
    logic signed [INTEGRAL_WIDTH-1:0] integ_sat;

    logic [1:0]                       term;
    logic [GAIN_W-1:0]                mac_gain;
    logic signed [OP_W-1:0]           mac_operand;
    logic signed [ACC_W-1:0]          acc;
    logic signed [ACC_W-1:0]          acc_clamp_o;
    logic signed [ACC_W-1:0]          acc_clamp_i;
    logic signed [UiW-1:0]            ui;
    logic [UiW-1:0]                   ui_mag;
    logic [DUTY_W-1:0]                duty;
    logic                             reverse;

    cpsp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    cpsp_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .gain    (mac_gain),
        .operand (mac_operand),
        .acc     (acc)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Position accumulator, saturating at 32 bits.
    always_comb
    begin
        pos_sum = (POS_W + 1)'(pos_reg) + (POS_W + 1)'($signed(s_axis_tdata));
        if (pos_sum[POS_W] != pos_sum[POS_W-1])
        begin
            pos_next = pos_sum[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
        end
        else
        begin
            pos_next = pos_sum[POS_W-1:0];
        end
    end

    // Error step, shared by both loops: error, difference and integrator update.
    always_comb
    begin
        inner_err = (state_reg == ST_IERR);
        eo        = EO_W'($signed(gains.position_target)) - EO_W'(pos_reg);
        ei        = EiW'(uo_reg) - (EiW'(spd_reg) <<< FRAC_BITS);

        if (inner_err)
        begin
            err_cur   = EO_W'(ei);
            prev_cur  = ED_W'(iprev_reg);
            integ_cur = iint_reg;
        end
        else
        begin
            err_cur   = eo;
            prev_cur  = ED_W'(oprev_reg);
            integ_cur = oint_reg;
        end

        diff      = ED_W'(err_cur) - prev_cur;
        integ_sum = SumW'(integ_cur) + SumW'(err_cur);

        priority if (integ_sum > IntMax)
        begin
            integ_sat = INTEGRAL_WIDTH'(IntMax);
        end
        else if (integ_sum < IntMin)
        begin
            integ_sat = INTEGRAL_WIDTH'(IntMin);
        end
        else
        begin
            integ_sat = INTEGRAL_WIDTH'(integ_sum);
        end
    end

    // Operand and gain for the current multiply: P, I and D terms in turn.
    always_comb
    begin
        term = step_reg[STEP_W-1:1];
        unique case (term)
            TERM_P:
            begin
                mac_operand = OP_W'(e_reg);
                mac_gain    = (state_reg == ST_IMAC) ? gains.inner_kp : gains.outer_kp;
            end
            TERM_I:
            begin
                mac_operand = (state_reg == ST_IMAC) ? OP_W'(iint_reg) : OP_W'(oint_reg);
                mac_gain    = (state_reg == ST_IMAC) ? gains.inner_ki : gains.outer_ki;
            end
            TERM_D:
            begin
                mac_operand = OP_W'(d_reg);
                mac_gain    = (state_reg == ST_IMAC) ? gains.inner_kd : gains.outer_kd;
            end
            default:
            begin
                mac_operand = '0;
                mac_gain    = '0;
            end
        endcase
    end

    // Output clamps and drive conversion.
    always_comb
    begin
        priority if (acc > OuterLim)
        begin
            acc_clamp_o = OuterLim;
        end
        else if (acc < -OuterLim)
        begin
            acc_clamp_o = -OuterLim;
        end
        else
        begin
            acc_clamp_o = acc;
        end

        priority if (acc > InnerLim)
        begin
            acc_clamp_i = InnerLim;
        end
        else if (acc < -InnerLim)
        begin
            acc_clamp_i = -InnerLim;
        end
        else
        begin
            acc_clamp_i = acc;
        end

        ui = UiW'(acc_clamp_i);
        if (ui[UiW-1])
        begin
            ui_mag = UiW'(-ui);
        end
        else
        begin
            ui_mag = UiW'(ui);
        end
        // Truncation toward zero: drop the fraction of the magnitude.
        duty    = ui_mag[2 * FRAC_BITS +: DUTY_W];
        reverse = ui[UiW-1] && (duty != '0);
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = '0;
        mac_ctl.issue = 1'b0;
        mac_ctl.first = (step_reg == '0);
        mac_ctl.hi    = step_reg[0];
        out_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_OERR;
                end
            end
            ST_OERR:
            begin
                state_next = ST_OMAC;
            end
            ST_OMAC, ST_IMAC:
            begin
                mac_ctl.issue = (step_reg < STEP_ISSUE);
                if (step_reg == STEP_LAST)
                begin
                    state_next = (state_reg == ST_OMAC) ? ST_OCLAMP : ST_FINISH;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_OCLAMP:
            begin
                state_next = ST_IERR;
            end
            ST_IERR:
            begin
                state_next = ST_IMAC;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            oint_reg      <= '0;
            iint_reg      <= '0;
            oprev_reg     <= '0;
            iprev_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_beat)
            begin
                pos_reg <= pos_next;
            end

            if (state_reg == ST_OERR)
            begin
                oint_reg  <= integ_sat;
                oprev_reg <= eo;
            end

            if (state_reg == ST_IERR)
            begin
                iint_reg  <= integ_sat;
                iprev_reg <= ei;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            spd_reg <= $signed(s_axis_tdata);
        end
        if (state_reg == ST_OERR || state_reg == ST_IERR)
        begin
            e_reg <= err_cur;
            d_reg <= diff;
        end
        if (state_reg == ST_OCLAMP)
        begin
            uo_reg <= UoW'(acc_clamp_o);
        end
        if (out_load)
        begin
            out_data_reg <= {pos_reg, reverse, duty};
        end
    end

    `CPSP_ASSERT_SAME(a_duty_range, m_axis_tvalid, m_axis_tdata[DUTY_W-1:0] <= DUTY_W'(INNER_LIMIT), "duty above the inner clamp")
    `CPSP_ASSERT_SAME(a_reverse_nonzero, m_axis_tvalid && m_axis_tdata[DUTY_W], m_axis_tdata[DUTY_W-1:0] != '0, "reverse set with zero duty")
    `CPSP_ASSERT_SAME(a_speed_target_range, state_reg == ST_IERR, (uo_reg <= UoLim) && (uo_reg >= -UoLim), "speed target outside the outer clamp")
    `CPSP_ASSERT_NEXT(a_position_monotonic, in_beat && !s_axis_tdata[SPD_W-1], pos_reg >= $past(pos_reg), "position wrapped on a forward count")
    `CPSP_ASSERT_NEXT(a_result_held, state_reg == ST_FINISH && m_axis_tvalid && !m_axis_tready, state_reg == ST_FINISH, "result loaded while the output was stalled")

endmodule
`default_nettype wire

FILE: rtl/cpsp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpsp_cfg_regs
// Gain and position target registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module cpsp_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cpsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpsp_pkg::CFG_DATA_W-1:0] cfg_data,
    output cpsp_pkg::cpsp_gains_t        gains
);
    import cpsp_pkg::*;

    cpsp_gains_t gains_reg;
    cpsp_gains_t gains_next;
    logic        wr_beat;

    assign cfg_ready = 1'b1;
    assign wr_beat   = cfg_valid & cfg_ready;
    assign gains     = gains_reg;

    always_comb
    begin
        gains_next = gains_reg;
        if (wr_beat)
        begin
            unique case (cfg_index)
                REG_OUTER_KP:        gains_next.outer_kp = cfg_data[GAIN_W-1:0];
                REG_OUTER_KI:        gains_next.outer_ki = cfg_data[GAIN_W-1:0];
                REG_OUTER_KD:        gains_next.outer_kd = cfg_data[GAIN_W-1:0];
                REG_INNER_KP:        gains_next.inner_kp = cfg_data[GAIN_W-1:0];
                REG_INNER_KI:        gains_next.inner_ki = cfg_data[GAIN_W-1:0];
                REG_INNER_KD:        gains_next.inner_kd = cfg_data[GAIN_W-1:0];
                REG_POSITION_TARGET: gains_next.position_target = cfg_data[POS_W-1:0];
                default:             gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.outer_kp        <= OUTER_KP_RST;
            gains_reg.outer_ki        <= OUTER_KI_RST;
            gains_reg.outer_kd        <= OUTER_KD_RST;
            gains_reg.inner_kp        <= INNER_KP_RST;
            gains_reg.inner_ki        <= INNER_KI_RST;
            gains_reg.inner_kd        <= INNER_KD_RST;
            gains_reg.position_target <= '0;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cpsp_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpsp_mac
// Shared multiply-accumulate unit: an unsigned gain times one 32-bit chunk of
// a signed operand per issued cycle, product registered, then added to the sum.
// ----------------------------------------------------------------------------
module cpsp_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cpsp_pkg::cpsp_mac_ctl_t             ctl,
    input  logic [cpsp_pkg::GAIN_W-1:0]         gain,
    input  logic signed [cpsp_pkg::OP_W-1:0]    operand,
    output logic signed [cpsp_pkg::ACC_W-1:0]   acc
);
    import cpsp_pkg::*;

    logic signed [CHUNK_W:0]   chunk;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_vld_reg;
    logic                      first_reg;
    logic                      hi_reg;
    logic signed [ACC_W-1:0]   aligned;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_reg;

    // The lower chunk is an unsigned digit; only the upper chunk carries the sign.
    always_comb
    begin
        if (ctl.hi)
        begin
            chunk = {operand[OP_W-1], operand[OP_W-1 -: CHUNK_W]};
        end
        else
        begin
            chunk = {1'b0, operand[CHUNK_W-1:0]};
        end
        prod_next = $signed({1'b0, gain}) * chunk;
    end

    always_comb
    begin
        if (hi_reg)
        begin
            aligned = ACC_W'(prod_reg) <<< CHUNK_W;
        end
        else
        begin
            aligned = ACC_W'(prod_reg);
        end

        priority if (!prod_vld_reg)
        begin
            acc_next = acc_reg;
        end
        else if (first_reg)
        begin
            acc_next = aligned;
        end
        else
        begin
            acc_next = acc_reg + aligned;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg  <= prod_next;
            first_reg <= ctl.first;
            hi_reg    <= ctl.hi;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire
